// ===== hw/rtl/nonoverlap_record_choice_enumerator_unit_defines.svh =====
// Assertion macros for the checker file of this block.
// Clock is i_clk, reset is i_rst_n (synchronous, active low).
`ifndef NONOVERLAP_RECORD_CHOICE_ENUMERATOR_UNIT_DEFINES_SVH
`define NONOVERLAP_RECORD_CHOICE_ENUMERATOR_UNIT_DEFINES_SVH

// Same-cycle implication.
`define NRCE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("nrce check failed");

// Next-cycle implication.
`define NRCE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("nrce check failed");

`endif

// ===== hw/rtl/nrce_pkg.sv =====
`timescale 1ns / 1ps

package nrce_pkg;

    // Request opcodes.
    typedef enum logic [2:0] {
        OP_WRITE_LENGTH  = 3'd0,
        OP_WRITE_ELEMENT = 3'd1,
        OP_SET_PICK      = 3'd2,
        OP_START         = 3'd3,
        OP_NEXT          = 3'd4
    } t_op;

    // Enumeration phase.
    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_FRESH   = 2'd1,
        PH_EMITTED = 2'd2,
        PH_DONE    = 2'd3
    } t_phase;

    // Search sequencer.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_BREAD,
        ST_BEVAL,
        ST_EMIT
    } t_state;

    localparam int CHOICE_SLOTS = 8;
    localparam int CHOICE_BITS  = 2;

endpackage

// ===== hw/rtl/nonoverlap_record_choice_enumerator_unit.sv =====
`timescale 1ns / 1ps

// Non-overlapping record choice enumerator. Load the element table (op 1),
// the record lengths (op 0) and the picked elements (op 2), then issue a start
// request (op 3) and one next request (op 4) per tuple wanted. Each next request
// returns the next tuple of record choices in lexicographic order (slot 0 most
// significant) for which every slot's element position plus chosen record length
// stays at or below the next slot's element position; found is 0 once the list
// is exhausted or before a start. Table, pick and start requests complete in the
// cycle they are accepted and give no result. A next request runs a search over
// one shared 33-bit add/compare unit fed by single-port tables: each slot check
// is a table read, then an evaluate, each carry step of the odometer is likewise
// a read, then an evaluate, and every pass restarts the check at slot 0, so the
// length of a search is data dependent. The result sits in an output register,
// so the block takes a new request while the previous result is still stalled;
// o_in_stall is high only while a search runs or its result waits for that
// register. Tables have no reset and no clearing pass.
module nonoverlap_record_choice_enumerator_unit
    import nrce_pkg::*;
#(
    parameter int MAX_ELEMENTS = 16,
    parameter int MAX_RECORDS  = 4,
    parameter int MAX_PICK     = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_op,
    input  logic [3:0]  i_element_index,
    input  logic [1:0]  i_record_index,
    input  logic [2:0]  i_slot_index,
    input  logic [31:0] i_position,
    input  logic [31:0] i_length,
    input  logic [2:0]  i_record_count,
    input  logic [3:0]  i_pick_count,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_found,
    output logic [15:0] o_choices,
    output logic [16:0] o_tuple_count
);

    localparam int EAW    = $clog2(MAX_ELEMENTS);
    localparam int RAW    = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
    localparam int LDEPTH = MAX_ELEMENTS * MAX_RECORDS;
    localparam int LAW    = $clog2(LDEPTH);
    localparam int RCW    = $clog2(MAX_RECORDS + 1);
    localparam int SW     = (MAX_PICK > 1) ? $clog2(MAX_PICK) : 1;
    localparam int PCW    = $clog2(MAX_PICK + 1);
    localparam int NCH    = (MAX_PICK < CHOICE_SLOTS) ? MAX_PICK : CHOICE_SLOTS;

    // Tables: written only from idle, read one address per cycle by the search.
    logic [31:0]    pos_mem [MAX_ELEMENTS];
    logic [RCW-1:0] rc_mem  [MAX_ELEMENTS];
    logic [31:0]    len_mem [LDEPTH];
    logic [EAW-1:0] r_pick  [MAX_PICK];

    // Registered table read data.
    logic [31:0]    r_pos_q;
    logic [RCW-1:0] r_rc_q;
    logic [31:0]    r_len_q;

    // Control state.
    t_state         r_state, n_state;
    t_phase         r_phase, n_phase;
    logic [PCW-1:0] r_idx, n_idx;
    logic [PCW-1:0] r_npick, n_npick;
    logic [RAW-1:0] r_odo [MAX_PICK];
    logic [RAW-1:0] n_odo [MAX_PICK];
    logic [16:0]    r_emitted, n_emitted;
    logic           r_hit, n_hit;
    logic           r_ovalid, n_ovalid;

    // Running end (position + length) of the previous slot.
    logic [32:0]    r_end, n_end;

    // Output payload.
    logic           r_found;
    logic [15:0]    r_choices;
    logic [16:0]    r_count;

    logic           w_in_acc;
    logic           w_load_out;
    logic           w_elem_ok;
    logic           w_rec_ok;
    logic           w_slot_ok;
    logic [LAW-1:0] w_wr_laddr;
    logic [RCW-1:0] w_wr_rc;
    logic [PCW-1:0] w_start_n;
    logic [SW-1:0]  w_slot;
    logic [EAW-1:0] w_rd_e;
    logic [LAW-1:0] w_rd_laddr;
    logic [RAW-1:0] w_odo_cur;
    logic [RCW:0]   w_odo_ext;
    logic [RCW:0]   w_rc_ext;
    logic [32:0]    w_sum;
    logic           w_bad;
    logic [15:0]    w_choices;

    assign o_in_stall = (r_state != ST_IDLE);
    assign w_in_acc   = i_in_valid && !o_in_stall;

    // Index range checks and write addressing.
    assign w_elem_ok  = (32'(i_element_index) < MAX_ELEMENTS);
    assign w_rec_ok   = (32'(i_record_index) < MAX_RECORDS);
    assign w_slot_ok  = (32'(i_slot_index) < MAX_PICK);
    assign w_wr_laddr = LAW'(32'(i_element_index) * MAX_RECORDS + 32'(i_record_index));
    assign w_wr_rc    = (32'(i_record_count) > MAX_RECORDS) ? RCW'(MAX_RECORDS)
                                                            : RCW'(i_record_count);

    always_comb begin
        if (i_pick_count == '0) begin
            w_start_n = PCW'(1);
        end else if (32'(i_pick_count) > MAX_PICK) begin
            w_start_n = PCW'(MAX_PICK);
        end else begin
            w_start_n = PCW'(i_pick_count);
        end
    end

    // Search addressing: the slot under the index register selects the element.
    assign w_slot     = r_idx[SW-1:0];
    assign w_odo_cur  = r_odo[w_slot];
    assign w_rd_e     = r_pick[w_slot];
    assign w_rd_laddr = LAW'(32'(w_rd_e) * MAX_RECORDS + 32'(w_odo_cur));

    // Shared add/compare unit.
    assign w_odo_ext = (RCW + 1)'(w_odo_cur);
    assign w_rc_ext  = (RCW + 1)'(r_rc_q);
    assign w_sum     = {1'b0, r_pos_q} + {1'b0, r_len_q};
    assign w_bad     = (w_odo_ext >= w_rc_ext) ||
                       ((r_idx != '0) && (r_end > {1'b0, r_pos_q}));

    // Table writes from idle requests, reads for the search.
    always_ff @(posedge i_clk) begin
        if (w_in_acc && (i_op == OP_WRITE_LENGTH) && w_elem_ok && w_rec_ok) begin
            len_mem[w_wr_laddr] <= i_length;
        end
        if (w_in_acc && (i_op == OP_WRITE_ELEMENT) && w_elem_ok) begin
            pos_mem[EAW'(i_element_index)] <= i_position;
            rc_mem[EAW'(i_element_index)]  <= w_wr_rc;
        end
        if (w_in_acc && (i_op == OP_SET_PICK) && w_elem_ok && w_slot_ok) begin
            r_pick[SW'(i_slot_index)] <= EAW'(i_element_index);
        end
        r_pos_q <= pos_mem[w_rd_e];
        r_rc_q  <= rc_mem[w_rd_e];
        r_len_q <= len_mem[w_rd_laddr];
    end

    // Sequencer: next state and datapath updates.
    always_comb begin
        n_state    = r_state;
        n_phase    = r_phase;
        n_idx      = r_idx;
        n_npick    = r_npick;
        n_odo      = r_odo;
        n_emitted  = r_emitted;
        n_hit      = r_hit;
        n_end      = r_end;
        n_ovalid   = r_ovalid && i_out_stall;
        w_load_out = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    case (t_op'(i_op))
                        OP_START: begin
                            n_npick   = w_start_n;
                            n_emitted = '0;
                            n_phase   = PH_FRESH;
                            for (int i = 0; i < MAX_PICK; i++) begin
                                n_odo[i] = '0;
                            end
                        end
                        OP_NEXT: begin
                            if (r_phase == PH_FRESH) begin
                                // check the all-zero tuple first
                                n_idx   = '0;
                                n_state = ST_READ;
                            end else if (r_phase == PH_EMITTED) begin
                                // advance past the last tuple given out
                                n_idx   = PCW'(r_npick - 1'b1);
                                n_state = ST_BREAD;
                            end else begin
                                n_hit   = 1'b0;
                                n_state = ST_EMIT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            ST_READ: begin
                n_state = ST_EVAL;
            end

            ST_EVAL: begin
                if (w_bad) begin
                    // drop this slot and everything after it, carry one slot up
                    for (int i = 0; i < MAX_PICK; i++) begin
                        if (i >= int'(r_idx)) begin
                            n_odo[i] = '0;
                        end
                    end
                    if (r_idx == '0) begin
                        n_phase = PH_DONE;
                        n_hit   = 1'b0;
                        n_state = ST_EMIT;
                    end else begin
                        n_idx   = PCW'(r_idx - 1'b1);
                        n_state = ST_BREAD;
                    end
                end else begin
                    n_end = w_sum;
                    if (PCW'(r_idx + 1'b1) == r_npick) begin
                        n_hit     = 1'b1;
                        n_phase   = PH_EMITTED;
                        n_emitted = r_emitted + 17'd1;
                        n_state   = ST_EMIT;
                    end else begin
                        n_idx   = PCW'(r_idx + 1'b1);
                        n_state = ST_READ;
                    end
                end
            end

            ST_BREAD: begin
                n_state = ST_BEVAL;
            end

            ST_BEVAL: begin
                if ((w_odo_ext + (RCW + 1)'(1)) < w_rc_ext) begin
                    n_odo[w_slot] = RAW'(w_odo_cur + 1'b1);
                    n_idx         = '0;
                    n_state       = ST_READ;
                end else begin
                    n_odo[w_slot] = '0;
                    if (r_idx == '0) begin
                        n_phase = PH_DONE;
                        n_hit   = 1'b0;
                        n_state = ST_EMIT;
                    end else begin
                        n_idx   = PCW'(r_idx - 1'b1);
                        n_state = ST_BREAD;
                    end
                end
            end

            ST_EMIT: begin
                // hold until the output register is free
                if (!r_ovalid || !i_out_stall) begin
                    w_load_out = 1'b1;
                    n_ovalid   = 1'b1;
                    n_state    = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Pack the odometer into the choices field.
    always_comb begin
        logic [RAW+1:0] tmp;
        w_choices = '0;
        for (int k = 0; k < NCH; k++) begin
            tmp = (RAW + 2)'(r_odo[k]);
            if (r_hit && (k < int'(r_npick))) begin
                w_choices[k*CHOICE_BITS +: CHOICE_BITS] = tmp[CHOICE_BITS-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_phase   <= PH_IDLE;
            r_idx     <= '0;
            r_npick   <= PCW'(1);
            r_emitted <= '0;
            r_hit     <= 1'b0;
            r_ovalid  <= 1'b0;
            for (int i = 0; i < MAX_PICK; i++) begin
                r_odo[i] <= '0;
            end
        end else begin
            r_state   <= n_state;
            r_phase   <= n_phase;
            r_idx     <= n_idx;
            r_npick   <= n_npick;
            r_emitted <= n_emitted;
            r_hit     <= n_hit;
            r_ovalid  <= n_ovalid;
            r_odo     <= n_odo;
        end
    end

    always_ff @(posedge i_clk) begin
        r_end <= n_end;
        if (w_load_out) begin
            r_found   <= r_hit;
            r_choices <= w_choices;
            r_count   <= r_emitted;
        end
    end

    assign o_out_valid   = r_ovalid;
    assign o_found       = r_found;
    assign o_choices     = r_choices;
    assign o_tuple_count = r_count;

endmodule

// ===== hw/rtl/nrce_checker.sv =====
`timescale 1ns / 1ps
`include "nonoverlap_record_choice_enumerator_unit_defines.svh"

module nrce_checker
    import nrce_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic [2:0]  i_op,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic        o_found,
    input logic [15:0] o_choices,
    input logic [16:0] o_tuple_count
);

    // an empty result carries no choices
    `NRCE_ASSERT_NOW(a_empty_no_choices, o_out_valid && !o_found, o_choices == '0)

    // a found tuple is always counted
    `NRCE_ASSERT_NOW(a_found_counted, o_out_valid && o_found, o_tuple_count != '0)

    // a next request always stalls the input before the next request is taken
    `NRCE_ASSERT_NEXT(a_next_busy, i_in_valid && !o_in_stall && i_op == OP_NEXT, o_in_stall)

    // other requests finish in the cycle they are taken
    `NRCE_ASSERT_NEXT(a_other_quick, i_in_valid && !o_in_stall && i_op != OP_NEXT, !o_in_stall)

    // a stalled result holds
    `NRCE_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_tuple_count))

endmodule

bind nonoverlap_record_choice_enumerator_unit nrce_checker u_nrce_checker (.*);
